/* hw/rtl/bpwu_pkg.sv */
package bpwu_pkg;

   // Request codes carried in req_type; codes 6 and 7 are unused.
   typedef enum logic [2:0] {
      REQ_WR_WEIGHT = 3'd0,
      REQ_WR_BIAS   = 3'd1,
      REQ_WR_PREV   = 3'd2,
      REQ_TRAIN     = 3'd3,
      REQ_RD_WEIGHT = 3'd4,
      REQ_RD_BIAS   = 3'd5
   } req_kind_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_RATE  = 2'd0;
   localparam logic [1:0] CSR_REGW  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_FETCH,
      ST_MUL,
      ST_SUM,
      ST_SCALE,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT_PUT,
      ST_READ_RD,
      ST_READ_PUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic gain;
      logic bias_mode;
      logic mul;
      logic sum;
      logic scale;
      logic write;
      logic j_clear;
      logic j_inc;
      logic out_emit;
      logic out_read;
      logic acc_clear;
   } cmd_type;

   typedef struct packed {
      logic node_ok;
      logic j_last;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/bpwu_ctrl.sv */
module bpwu_ctrl
   import bpwu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_type,
   input  logic       req_last_node,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      bias_ff, bias_in;
   logic      last_ff, last_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bias_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bias_ff  <= bias_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      bias_in       = bias_ff;
      cmd           = '0;
      cmd.bias_mode = bias_ff;
      req_stall     = (state_ff != ST_IDLE);
      accept        = req_valid && !req_stall;
      last_in       = accept ? req_last_node : last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept) begin
               unique case (req_kind_type'(req_type))
                  REQ_TRAIN: begin
                     if (st.node_ok) begin
                        state_in = ST_GAIN;
                     end else if (req_last_node) begin
                        cmd.j_clear = 1'b1;
                        state_in    = ST_EMIT_RD;
                     end
                  end
                  REQ_RD_WEIGHT, REQ_RD_BIAS: state_in = ST_READ_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_GAIN: begin
            cmd.gain    = 1'b1;
            cmd.j_clear = 1'b1;
            bias_in     = 1'b0;
            state_in    = ST_FETCH;
         end
         ST_FETCH: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            if (bias_ff) begin
               bias_in = 1'b0;
               if (last_ff) begin
                  cmd.j_clear = 1'b1;
                  state_in    = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (st.j_last) begin
               bias_in  = 1'b1;
               state_in = ST_FETCH;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_FETCH;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_PUT;
         ST_EMIT_PUT: begin
            if (st.out_free) begin
               cmd.out_emit = 1'b1;
               if (st.j_last) begin
                  cmd.acc_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.j_inc = 1'b1;
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         ST_READ_RD: state_in = ST_READ_PUT;
         ST_READ_PUT: begin
            if (st.out_free) begin
               cmd.out_read = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/bpwu_datapath.sv */
module bpwu_datapath
   import bpwu_pkg::*;
#(
   parameter int LAYER_NODES = 64,
   parameter int PREV_NODES  = 64
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         st,
   input  logic [2:0]         req_type,
   input  logic [5:0]         req_node_index,
   input  logic [5:0]         req_prev_index,
   input  logic signed [15:0] req_data_value,
   input  logic signed [15:0] req_error_value,
   input  logic signed [15:0] req_deriv_value,
   input  logic [15:0]        learning_rate,
   input  logic [15:0]        reg_weight,
   input  logic [6:0]         prev_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [5:0]         rsp_result_index,
   output logic signed [15:0] rsp_result_value,
   output logic               rsp_last
);

   localparam int NW = (LAYER_NODES > 1) ? $clog2(LAYER_NODES) : 1;
   localparam int PW = (PREV_NODES > 1) ? $clog2(PREV_NODES) : 1;
   localparam int WA = NW + PW;
   localparam int WD = LAYER_NODES * (2 ** PW);

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'sh7FFF;
      if (v < -64'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   logic signed [15:0] weight_mem [0:WD-1];
   logic signed [15:0] bias_mem   [0:LAYER_NODES-1];
   logic signed [15:0] prev_mem   [0:PREV_NODES-1];
   logic signed [23:0] acc_mem    [0:PREV_NODES-1];
   logic [PREV_NODES-1:0] acc_vld_ff;

   logic [NW-1:0] node_ff;
   logic [PW-1:0] prev_ff, j_ff;
   logic          node_ok_ff, prev_ok_ff, rd_bias_ff;
   logic signed [15:0] e_ff, d_ff, g_ff, opnd_ff;
   logic signed [15:0] w_rd_ff, b_rd_ff, x_rd_ff;
   logic signed [23:0] acc_rd_ff;
   logic               acc_vld_rd_ff;
   logic signed [31:0] gw_ff, gx_ff;
   logic signed [32:0] rw_ff;
   logic signed [33:0] grd_ff;
   logic [32:0]        lo_ff;
   logic signed [33:0] hi_ff;
   logic               rsp_valid_ff, kind_ff, last_ff;
   logic [5:0]         index_ff;
   logic signed [15:0] value_ff;

   logic          node_ok, prev_ok, acc_we, w_we, b_we;
   logic [NW-1:0] req_node;
   logic [PW-1:0] req_prev;
   logic [WA-1:0] w_waddr, w_raddr;
   logic [NW-1:0] b_waddr;
   logic signed [15:0] w_wdata, b_wdata, new_val, opnd, rd_val;
   logic [6:0]         cnt;
   logic signed [31:0] prod_ed;
   logic signed [32:0] g_shift, be;
   logic signed [23:0] acc_val, acc_new;
   logic signed [51:0] total;
   req_kind_type       kind;

   assign kind     = req_kind_type'(req_type);
   assign node_ok  = ({3'b0, req_node_index} < 9'(LAYER_NODES));
   assign prev_ok  = ({1'b0, req_prev_index} < 7'(PREV_NODES));
   assign req_node = NW'(req_node_index);
   assign req_prev = PW'(req_prev_index);

   always_comb begin
      if (prev_count == 7'd0) cnt = 7'd1;
      else if (prev_count > 7'(PREV_NODES)) cnt = 7'(PREV_NODES);
      else cnt = prev_count;
   end

   assign st.node_ok  = node_ok;
   assign st.j_last   = (7'(j_ff) == cnt - 7'd1);
   assign st.out_free = !rsp_valid_ff || !rsp_stall;

   // Arithmetic of one element step.
   assign prod_ed = e_ff * d_ff;
   assign g_shift = (33'(prod_ed) + 33'sd1024) >>> 11;
   assign opnd    = cmd.bias_mode ? b_rd_ff : w_rd_ff;
   assign acc_val = acc_vld_rd_ff ? acc_rd_ff : 24'sd0;
   assign be      = (33'(gw_ff) + 33'sd4096) >>> 13;
   assign acc_new = sat24(64'(acc_val) + 64'(be));
   assign total   = (52'(hi_ff) <<< 17) + 52'($signed({1'b0, lo_ff})) + 52'sd8388608;
   assign new_val = sat16(64'(opnd_ff) - 64'(total >>> 24));

   // Memory port selection. The weight read address follows the element
   // counter during training and the latched previous index during a read;
   // the latched index is zero for a train word and the counter is zero
   // outside training, so the two can simply be merged.
   assign w_we    = (cmd.accept && kind == REQ_WR_WEIGHT && node_ok && prev_ok)
                    || (cmd.write && !cmd.bias_mode);
   assign w_waddr = cmd.accept ? {req_node, req_prev} : {node_ff, j_ff};
   assign w_wdata = cmd.accept ? req_data_value : new_val;
   assign w_raddr = {node_ff, j_ff | prev_ff};
   assign b_we    = (cmd.accept && kind == REQ_WR_BIAS && node_ok)
                    || (cmd.write && cmd.bias_mode);
   assign b_waddr = cmd.accept ? req_node : node_ff;
   assign b_wdata = cmd.accept ? req_data_value : new_val;
   assign acc_we  = cmd.sum && !cmd.bias_mode;

   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_waddr] <= w_wdata;
      w_rd_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) bias_mem[b_waddr] <= b_wdata;
      b_rd_ff <= bias_mem[node_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && kind == REQ_WR_PREV && prev_ok) prev_mem[req_prev] <= req_data_value;
      x_rd_ff <= prev_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[j_ff] <= acc_new;
      acc_rd_ff     <= acc_mem[j_ff];
      acc_vld_rd_ff <= acc_vld_ff[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (cmd.acc_clear) begin
         acc_vld_ff <= '0;
      end else if (acc_we) begin
         acc_vld_ff[j_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else if (cmd.j_clear || (cmd.accept)) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         node_ff    <= req_node;
         prev_ff    <= (prev_ok && kind != REQ_TRAIN) ? req_prev : '0;
         node_ok_ff <= node_ok;
         prev_ok_ff <= prev_ok;
         rd_bias_ff <= (kind == REQ_RD_BIAS);
         e_ff       <= req_error_value;
         d_ff       <= req_deriv_value;
      end
      if (cmd.gain) g_ff <= sat16(64'(g_shift));
      if (cmd.mul) begin
         opnd_ff <= opnd;
         gw_ff   <= g_ff * opnd;
         gx_ff   <= cmd.bias_mode ? (32'(g_ff) <<< 12) : g_ff * x_rd_ff;
         rw_ff   <= $signed({1'b0, reg_weight}) * opnd;
      end
      if (cmd.sum) grd_ff <= 34'(gx_ff) + 34'(rw_ff);
      if (cmd.scale) begin
         lo_ff <= 33'(learning_rate) * 33'(grd_ff[16:0]);
         hi_ff <= $signed({1'b0, learning_rate}) * $signed(grd_ff[33:17]);
      end
   end

   always_comb begin
      if (rd_bias_ff) rd_val = node_ok_ff ? b_rd_ff : 16'sd0;
      else rd_val = (node_ok_ff && prev_ok_ff) ? w_rd_ff : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_emit || cmd.out_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_emit) begin
         kind_ff  <= 1'b1;
         index_ff <= 6'(j_ff);
         value_ff <= sat16(64'(acc_val));
         last_ff  <= st.j_last;
      end else if (cmd.out_read) begin
         kind_ff  <= 1'b0;
         index_ff <= 6'd0;
         value_ff <= rd_val;
         last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_result_index = index_ff;
   assign rsp_result_value = value_ff;
   assign rsp_last         = last_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_emit || cmd.out_read) |-> st.out_free)
      else $error("result word loaded over a waiting word");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_clear |=> (acc_vld_ff == '0))
      else $error("back-error accumulator not cleared after emission");

   a_acc_mark: assert property (@(posedge clock) disable iff (reset)
      acc_we |=> acc_vld_ff[$past(j_ff)])
      else $error("accumulated entry not marked valid");

endmodule

/* hw/rtl/backprop_weight_update.sv */
// Layer training engine in signed Q4.12 fixed point.
// Request words arrive on the req_ channel (valid/stall); a word is taken
// at a clock edge with req_valid high and req_stall low. Write words load a
// weight, a bias or a previous-layer value and finish in the accept cycle.
// Read words return one result word. A train word runs a read-modify-write
// over the first prev_count previous-layer weights of its node (a count of
// zero acts as one, capped at PREV_NODES), then over the node's bias,
// through one shared multiply and accumulate datapath that takes each
// element through fetch, multiply, sum, scale and write. With last_node
// set, the back-error vector follows as one result word per element, the
// final one marked by rsp_last, and the accumulator is then cleared.
// Result words sit in an output register; while rsp_stall is high the word
// holds and the engine waits before placing the next one. A waiting result
// does not block acceptance of a new request word.
// Reset clears the controller, the output register, the configuration
// registers (rate 41, L2 weight 0, count 64) and the accumulator valid bits.
// Weight, bias and previous-value memories hold nothing until written.
module backprop_weight_update
   import bpwu_pkg::*;
#(
   parameter int LAYER_NODES = 64,
   parameter int PREV_NODES  = 64
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [5:0]         req_node_index,
   input  logic [5:0]         req_prev_index,
   input  logic signed [15:0] req_data_value,
   input  logic signed [15:0] req_error_value,
   input  logic signed [15:0] req_deriv_value,
   input  logic               req_last_node,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [5:0]         rsp_result_index,
   output logic signed [15:0] rsp_result_value,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cmd_type    cmd;
   status_type st;

   // Configuration registers: one word each at byte offsets 0, 4 and 8.
   logic [15:0] rate_ff, rate_in;
   logic [15:0] regw_ff, regw_in;
   logic [6:0]  count_ff, count_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      rate_in  = rate_ff;
      regw_in  = regw_ff;
      count_in = count_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_RATE:  rate_in  = csr_pwdata[15:0];
            CSR_REGW:  regw_in  = csr_pwdata[15:0];
            CSR_COUNT: count_in = csr_pwdata[6:0];
            default:   rate_in  = rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= 16'd41;
         regw_ff  <= 16'd0;
         count_ff <= 7'd64;
      end else begin
         rate_ff  <= rate_in;
         regw_ff  <= regw_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_RATE:  csr_prdata = {16'd0, rate_ff};
         CSR_REGW:  csr_prdata = {16'd0, regw_ff};
         CSR_COUNT: csr_prdata = {25'd0, count_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   bpwu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_type      (req_type),
      .req_last_node (req_last_node),
      .req_stall     (req_stall),
      .st            (st),
      .cmd           (cmd)
   );

   bpwu_datapath #(
      .LAYER_NODES (LAYER_NODES),
      .PREV_NODES  (PREV_NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_type         (req_type),
      .req_node_index   (req_node_index),
      .req_prev_index   (req_prev_index),
      .req_data_value   (req_data_value),
      .req_error_value  (req_error_value),
      .req_deriv_value  (req_deriv_value),
      .learning_rate    (rate_ff),
      .reg_weight       (regw_ff),
      .prev_count       (count_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last)
   );

endmodule

/* test/bpwu_checker.sv */
module bpwu_checker
   import bpwu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [5:0]         req_node_index,
   input  logic [5:0]         req_prev_index,
   input  logic signed [15:0] req_data_value,
   input  logic signed [15:0] req_error_value,
   input  logic signed [15:0] req_deriv_value,
   input  logic               req_last_node,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_result_kind,
   input  logic [5:0]         rsp_result_index,
   input  logic signed [15:0] rsp_result_value,
   input  logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output int                 fail_count,
   output int                 pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              kind;
      logic [5:0]        index;
      logic signed [15:0] value;
      logic              last;
   } rsp_word_type;

   logic signed [15:0] weights [0:4095];
   logic signed [15:0] biases  [0:63];
   logic signed [15:0] prevs   [0:63];
   longint             back_acc [0:63];
   logic [15:0]        rate_q, regw_q;
   logic [6:0]         count_q;
   rsp_word_type       expected_words [$];

   assign pending_words = expected_words.size();

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic signed [15:0] step_down(longint val, longint grad);
      longint delta;
      delta = fshift(longint'(rate_q) * grad + (longint'(1) << 23), 24);
      return 16'(sat(val - delta, -32768, 32767));
   endfunction

   task automatic predict_word();
      int           cnt;
      longint       g, w, grad;
      rsp_word_type r;
      cnt = (count_q < 1) ? 1 : ((count_q > 64) ? 64 : int'(count_q));
      case (req_type)
         REQ_WR_WEIGHT: weights[{req_node_index, req_prev_index}] = req_data_value;
         REQ_WR_BIAS:   biases[req_node_index] = req_data_value;
         REQ_WR_PREV:   prevs[req_prev_index] = req_data_value;
         REQ_TRAIN: begin
            g = sat(fshift(longint'(req_error_value) * req_deriv_value + 1024, 11),
                    -32768, 32767);
            for (int j = 0; j < cnt; j++) begin
               w = weights[{req_node_index, 6'(j)}];
               back_acc[j] = sat(back_acc[j] + fshift(g * w + 4096, 13),
                                 -8388608, 8388607);
               grad = g * prevs[j] + longint'(regw_q) * w;
               weights[{req_node_index, 6'(j)}] = step_down(w, grad);
            end
            grad = g * 4096 + longint'(regw_q) * biases[req_node_index];
            biases[req_node_index] = step_down(biases[req_node_index], grad);
            if (req_last_node) begin
               for (int j = 0; j < cnt; j++) begin
                  r.kind  = 1'b1;
                  r.index = 6'(j);
                  r.value = 16'(sat(back_acc[j], -32768, 32767));
                  r.last  = (j + 1 == cnt);
                  expected_words.push_back(r);
               end
               for (int j = 0; j < 64; j++) back_acc[j] = 0;
            end
         end
         REQ_RD_WEIGHT: begin
            r = '{1'b0, 6'd0, weights[{req_node_index, req_prev_index}], 1'b1};
            expected_words.push_back(r);
         end
         REQ_RD_BIAS: begin
            r = '{1'b0, 6'd0, biases[req_node_index], 1'b1};
            expected_words.push_back(r);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         rate_q = 16'd41;
         regw_q = 16'd0;
         count_q = 7'd64;
         for (int j = 0; j < 64; j++) back_acc[j] = 0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               CSR_RATE:  rate_q = csr_pwdata[15:0];
               CSR_REGW:  regw_q = csr_pwdata[15:0];
               CSR_COUNT: count_q = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word value %0d", rsp_result_value);
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               if (e.kind !== rsp_result_kind) begin
                  $error("result_kind expected %0d actual %0d", e.kind, rsp_result_kind);
                  fail_count++;
               end
               if (e.index !== rsp_result_index) begin
                  $error("result_index expected %0d actual %0d", e.index,
                         rsp_result_index);
                  fail_count++;
               end
               if (e.value !== rsp_result_value) begin
                  $error("result_value expected %0d actual %0d", e.value,
                         rsp_result_value);
                  fail_count++;
               end
               if (e.last !== rsp_last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) predict_word();
      end
   end
endmodule

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bpwu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_type = REQ_WR_WEIGHT;
   logic [5:0]         req_node_index = '0;
   logic [5:0]         req_prev_index = '0;
   logic signed [15:0] req_data_value = '0;
   logic signed [15:0] req_error_value = '0;
   logic signed [15:0] req_deriv_value = '0;
   logic               req_last_node = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_kind;
   logic [5:0]         rsp_result_index;
   logic signed [15:0] rsp_result_value;
   logic               rsp_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count;
   int                 pending_words;
   int                 idle_cycles = 0;
   int                 stall_mode = 0;

   // Nodes 0..3 get the first ROW_LEN weights and a bias, and the first
   // ROW_LEN previous values are loaded, so that training and reading only
   // ever touch written entries. The element count never exceeds ROW_LEN.
   localparam int NODES_USED = 4;
   localparam int ROW_LEN    = 8;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   backprop_weight_update dut (.*);

   bpwu_checker checker_i (.*);

   // The receiver stalls in phases: free running, light random, heavy random.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // The watchdog counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[backprop_weight_update] ERROR");
         $finish;
      end
   end

   // One configuration write: a setup phase followed by an access phase.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Presents one request word and holds it until the block takes it.
   // An optional random gap is left idle first, so words come in bursts.
   task automatic send_word(logic [2:0] kind, logic [5:0] node, logic [5:0] pidx,
                            logic [15:0] data, logic [15:0] err, logic [15:0] der,
                            logic lastn, int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_node_index  <= node;
      req_prev_index  <= pidx;
      req_data_value  <= data;
      req_error_value <= err;
      req_deriv_value <= der;
      req_last_node   <= lastn;
      do @(posedge clock); while (req_stall);
   endtask

   // Lowers valid and waits until every expected word has come back,
   // then lets a train pass settle before the registers may change.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(16'(-1) * int'($urandom_range(1, 8)) * 64);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_rows(int gapmax);
      for (int n = 0; n < NODES_USED; n++) begin
         for (int p = 0; p < ROW_LEN; p++)
            send_word(REQ_WR_WEIGHT, 6'(n), 6'(p), rand_q(), 16'($urandom), 16'($urandom),
                      1'($urandom), $urandom_range(0, gapmax));
         send_word(REQ_WR_BIAS, 6'(n), 6'($urandom), rand_q(), 16'($urandom),
                   16'($urandom), 1'($urandom), $urandom_range(0, gapmax));
      end
      for (int p = 0; p < ROW_LEN; p++)
         send_word(REQ_WR_PREV, 6'($urandom), 6'(p), rand_q(), 16'($urandom),
                   16'($urandom), 1'($urandom), $urandom_range(0, gapmax));
   endtask

   // Random traffic: mostly trains and reads on loaded rows, sometimes a
   // rewrite, a broken request code, or a train with the last mark.
   task automatic random_phase(int words);
      int          pick, gap, burst;
      logic [2:0]  kind;
      burst = 0;
      for (int i = 0; i < words; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
         end else begin
            gap = 0;
         end
         burst--;
         pick = $urandom_range(0, 19);
         if (pick < 7) kind = REQ_TRAIN;
         else if (pick < 11) kind = REQ_RD_WEIGHT;
         else if (pick < 13) kind = REQ_RD_BIAS;
         else if (pick < 15) kind = REQ_WR_WEIGHT;
         else if (pick < 16) kind = REQ_WR_BIAS;
         else if (pick < 18) kind = REQ_WR_PREV;
         else kind = 3'($urandom_range(6, 7));
         send_word(kind, 6'($urandom_range(0, NODES_USED - 1)),
                   6'($urandom_range(0, ROW_LEN - 1)), rand_q(),
                   rand_q(), rand_q(), ($urandom_range(0, 2) == 0), gap);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset rate and L2 weight: load, then extremes.
      csr_write(CSR_COUNT, 32'(ROW_LEN));
      load_rows(0);
      send_word(REQ_RD_WEIGHT, 6'd0, 6'(ROW_LEN - 1), '0, '0, '0, 1'b1, 0);
      send_word(REQ_RD_BIAS, 6'd3, 6'd0, '0, '0, '0, 1'b0, 0);
      send_word(REQ_TRAIN, 6'd0, 6'd0, '0, 16'h7FFF, 16'h7FFF, 1'b0, 0);
      send_word(REQ_TRAIN, 6'd1, 6'd0, '0, 16'h8000, 16'h8000, 1'b0, 0);
      send_word(REQ_TRAIN, 6'd2, 6'd0, '0, 16'h8000, 16'h7FFF, 1'b1, 0);
      send_word(3'd6, 6'd1, 6'd1, '0, '0, '0, 1'b1, 0);
      send_word(3'd7, 6'd2, 6'd2, '0, '0, '0, 1'b1, 0);
      send_word(REQ_WR_PREV, 6'd63, 6'd0, 16'h8000, '0, '0, 1'b1, 0);
      send_word(REQ_TRAIN, 6'd3, 6'd0, '0, 16'h1000, 16'h1000, 1'b1, 0);
      send_word(REQ_RD_WEIGHT, 6'd3, 6'd0, '0, '0, '0, 1'b0, 0);
      drain();

      // Count of zero acts as one; rate and L2 at their maximum.
      csr_write(CSR_RATE, 32'hFFFF);
      csr_write(CSR_REGW, 32'hFFFF);
      csr_write(CSR_COUNT, 32'd0);
      send_word(REQ_TRAIN, 6'd1, 6'd0, '0, 16'h7FFF, 16'h8000, 1'b1, 0);
      send_word(REQ_RD_WEIGHT, 6'd1, 6'd0, '0, '0, '0, 1'b0, 0);
      send_word(REQ_RD_BIAS, 6'd1, 6'd0, '0, '0, '0, 1'b0, 0);
      drain();

      // Full loaded row with rate and L2 at zero: only the back-error moves.
      csr_write(CSR_RATE, 32'd0);
      csr_write(CSR_REGW, 32'd0);
      csr_write(CSR_COUNT, 32'(ROW_LEN));
      send_word(REQ_TRAIN, 6'd2, 6'd0, '0, 16'h4000, 16'h2000, 1'b1, 0);
      drain();

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(CSR_RATE, 32'($urandom_range(0, 65535)));
         csr_write(CSR_REGW, 32'($urandom_range(0, 4096)));
         csr_write(CSR_COUNT, 32'($urandom_range(1, ROW_LEN)));
         random_phase(22);
         drain();
      end

      // All stimulus is in; wait for the tail, bounded by the watchdog.
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("[backprop_weight_update] OK");
      else
         $display("[backprop_weight_update] ERROR");
      $finish;
   end
endmodule
